[rtl/cpu65_pkg.sv]
// Package: shared types, flag masks and opcode field codes for the 6502 execute unit.
`default_nettype none

package cpu65_pkg;

    // status bit positions, NV-BDIZC
    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_Z_BIT = 1;
    localparam int FLAG_I_BIT = 2;
    localparam int FLAG_D_BIT = 3;
    localparam int FLAG_B_BIT = 4;
    localparam int FLAG_V_BIT = 6;
    localparam int FLAG_N_BIT = 7;

    localparam logic [7:0] RST_ACC    = 8'h00;
    localparam logic [7:0] RST_INDEX  = 8'h00;
    localparam logic [7:0] RST_STATUS = 8'h20;
    localparam logic [7:0] RST_SP     = 8'hFF;

    localparam logic [7:0] PHP_SET_MASK  = 8'h30;
    localparam logic [7:0] PLP_KEEP_MASK = 8'hCF;
    localparam logic [7:0] PLP_SET_MASK  = 8'h20;

    // opcode low field
    localparam logic [1:0] LO_CTL = 2'd0;
    localparam logic [1:0] LO_ALU = 2'd1;
    localparam logic [1:0] LO_RMW = 2'd2;

    // opcode middle field
    localparam logic [2:0] MID_IMM  = 3'd0;
    localparam logic [2:0] MID_ZP   = 3'd1;
    localparam logic [2:0] MID_IMPL = 3'd2;
    localparam logic [2:0] MID_ABS  = 3'd3;
    localparam logic [2:0] MID_BR   = 3'd4;
    localparam logic [2:0] MID_ZPX  = 3'd5;
    localparam logic [2:0] MID_FLG  = 3'd6;

    // opcode high field, ALU group
    localparam logic [2:0] ALU_ORA = 3'd0;
    localparam logic [2:0] ALU_AND = 3'd1;
    localparam logic [2:0] ALU_EOR = 3'd2;
    localparam logic [2:0] ALU_ADC = 3'd3;
    localparam logic [2:0] ALU_STA = 3'd4;
    localparam logic [2:0] ALU_LDA = 3'd5;
    localparam logic [2:0] ALU_CMP = 3'd6;
    localparam logic [2:0] ALU_SBC = 3'd7;

    // opcode high field, implied control group
    localparam logic [2:0] IMP_PHP = 3'd0;
    localparam logic [2:0] IMP_PLP = 3'd1;
    localparam logic [2:0] IMP_PHA = 3'd2;
    localparam logic [2:0] IMP_PLA = 3'd3;
    localparam logic [2:0] IMP_DEY = 3'd4;
    localparam logic [2:0] IMP_TAY = 3'd5;
    localparam logic [2:0] IMP_INY = 3'd6;
    localparam logic [2:0] IMP_INX = 3'd7;

    localparam logic [2:0] HI_BIT  = 3'd1;
    localparam logic [2:0] HI_STOR = 3'd4;
    localparam logic [2:0] HI_LOAD = 3'd5;
    localparam logic [2:0] HI_CPY  = 3'd6;
    localparam logic [2:0] HI_CPX  = 3'd7;
    localparam logic [2:0] HI_TYA  = 3'd4;
    localparam logic [2:0] HI_CLV  = 3'd5;

    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_TSX = 8'hBA;

    typedef enum logic [1:0] {
        SA_NONE = 2'd0,
        SA_PUSH = 2'd1,
        SA_PULL = 2'd2
    } t_stack_acc;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] s;
    } t_cpu_state;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       write_back;
        logic       branch_taken;
        t_stack_acc stack_access;
        logic [7:0] stack_slot;
    } t_exec_result;

    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[FLAG_N_BIT] = v[7];
        r[FLAG_Z_BIT] = (v == 8'h00);
        return r;
    endfunction

    function automatic logic [7:0] f_cmp(input logic [7:0] p, input logic [7:0] r,
                                         input logic [7:0] v);
        logic [7:0] d;
        logic [7:0] q;
        d = r - v;
        q = p;
        q[FLAG_N_BIT] = d[7];
        q[FLAG_Z_BIT] = (r == v);
        q[FLAG_C_BIT] = (r >= v);
        return q;
    endfunction

endpackage

`default_nettype wire

[rtl/cpu65_if.sv]
// Interfaces: valid/ready channels for instruction items and execute results.
`default_nettype none

interface cpu65_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface cpu65_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       write_back;
    logic       branch_taken;
    logic [1:0] stack_access;
    logic [7:0] stack_slot;
    logic [7:0] acc_out;
    logic [7:0] index_x_out;
    logic [7:0] index_y_out;
    logic [7:0] status_out;
    logic [7:0] stack_pointer_out;

    modport source (
        output valid, output result_byte, output write_back, output branch_taken,
        output stack_access, output stack_slot, output acc_out, output index_x_out,
        output index_y_out, output status_out, output stack_pointer_out,
        input ready
    );
    modport sink (
        input valid, input result_byte, input write_back, input branch_taken,
        input stack_access, input stack_slot, input acc_out, input index_x_out,
        input index_y_out, input status_out, input stack_pointer_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/cpu65_exec.sv]
// Combinational execute logic: decodes one opcode and computes next state and result.
`default_nettype none

module cpu65_exec
    import cpu65_pkg::*;
(
    input  t_cpu_state   i_state,
    input  logic [7:0]   i_opcode,
    input  logic [7:0]   i_operand,
    output t_cpu_state   o_state,
    output t_exec_result o_result
);

    logic [2:0] hi;
    logic [2:0] mid;
    logic [1:0] lo;
    logic       odd;
    logic [7:0] a, x, y, p, s, v;

    logic [7:0] add_m;
    logic [8:0] add_sum;
    logic       add_ovf;
    logic [7:0] add_p;

    logic [7:0] sh_in;
    logic [7:0] sh_out;
    logic       sh_cout;
    logic [7:0] sh_p;

    logic [7:0] br_mask;
    logic [7:0] flg_mask;
    logic [7:0] rmw_val;

    assign hi  = i_opcode[7:5];
    assign mid = i_opcode[4:2];
    assign lo  = i_opcode[1:0];
    assign odd = mid[0];
    assign a   = i_state.a;
    assign x   = i_state.x;
    assign y   = i_state.y;
    assign p   = i_state.p;
    assign s   = i_state.s;
    assign v   = i_operand;

    // shared adder for ADC and SBC
    assign add_m   = hi[2] ? ~v : v;
    assign add_sum = {1'b0, a} + {1'b0, add_m} + {8'h00, p[FLAG_C_BIT]};
    assign add_ovf = ~(a[7] ^ add_m[7]) & (a[7] ^ add_sum[7]);
    assign add_p   = f_nz({p[7], add_ovf, p[5:1], add_sum[8]}, add_sum[7:0]);

    // shared shifter: hi[1] picks right, hi[0] picks rotate
    assign sh_in = (mid == MID_IMPL) ? a : v;
    always_comb begin
        if (!hi[1]) begin
            sh_cout = sh_in[7];
            sh_out  = {sh_in[6:0], hi[0] & p[FLAG_C_BIT]};
        end else begin
            sh_cout = sh_in[0];
            sh_out  = {hi[0] & p[FLAG_C_BIT], sh_in[7:1]};
        end
    end
    assign sh_p = f_nz({p[7:1], sh_cout}, sh_out);

    always_comb begin
        case (hi[2:1])
            2'd0:    br_mask = 8'h01 << FLAG_N_BIT;
            2'd1:    br_mask = 8'h01 << FLAG_V_BIT;
            2'd2:    br_mask = 8'h01 << FLAG_C_BIT;
            default: br_mask = 8'h01 << FLAG_Z_BIT;
        endcase
        case (hi[2:1])
            2'd0:    flg_mask = 8'h01 << FLAG_C_BIT;
            2'd1:    flg_mask = 8'h01 << FLAG_I_BIT;
            2'd2:    flg_mask = 8'h01 << FLAG_V_BIT;
            default: flg_mask = 8'h01 << FLAG_D_BIT;
        endcase
    end

    assign rmw_val = (hi == HI_CPY) ? (v - 8'd1) : (v + 8'd1);

    always_comb begin
        o_state  = i_state;
        o_result = '{result_byte: 8'h00, write_back: 1'b0, branch_taken: 1'b0,
                     stack_access: SA_NONE, stack_slot: 8'h00};

        if (lo == LO_ALU) begin
            case (hi)
                ALU_ORA: begin
                    o_state.a = a | v;
                    o_state.p = f_nz(p, a | v);
                end
                ALU_AND: begin
                    o_state.a = a & v;
                    o_state.p = f_nz(p, a & v);
                end
                ALU_EOR: begin
                    o_state.a = a ^ v;
                    o_state.p = f_nz(p, a ^ v);
                end
                ALU_ADC, ALU_SBC: begin
                    o_state.a = add_sum[7:0];
                    o_state.p = add_p;
                end
                ALU_STA: begin
                    if (mid != MID_IMPL) begin
                        o_result.result_byte = a;
                        o_result.write_back  = 1'b1;
                    end
                end
                ALU_LDA: begin
                    o_state.a = v;
                    o_state.p = f_nz(p, v);
                end
                ALU_CMP: o_state.p = f_cmp(p, a, v);
                default: o_state = i_state;
            endcase
        end else if (lo == LO_RMW && !hi[2]) begin
            if (mid == MID_IMPL) begin
                o_state.a = sh_out;
                o_state.p = sh_p;
            end else if (odd) begin
                o_state.p = sh_p;
                o_result.result_byte = sh_out;
                o_result.write_back  = 1'b1;
            end
        end else if (lo == LO_CTL && mid == MID_BR) begin
            o_result.branch_taken = (((p & br_mask) != 8'h00) == hi[0]);
        end else if (lo == LO_CTL && mid == MID_FLG) begin
            if (hi == HI_TYA) begin
                o_state.a = y;
                o_state.p = f_nz(p, y);
            end else if (hi == HI_CLV) begin
                o_state.p[FLAG_V_BIT] = 1'b0;
            end else if (hi[0]) begin
                o_state.p = p | flg_mask;
            end else begin
                o_state.p = p & ~flg_mask;
            end
        end else if (lo == LO_CTL && mid == MID_IMPL) begin
            case (hi)
                IMP_PHP, IMP_PHA: begin
                    o_result.result_byte  = (hi == IMP_PHP) ? (p | PHP_SET_MASK) : a;
                    o_result.write_back   = 1'b1;
                    o_result.stack_access = SA_PUSH;
                    o_result.stack_slot   = s;
                    o_state.s             = s - 8'd1;
                end
                IMP_PLP, IMP_PLA: begin
                    o_state.s             = s + 8'd1;
                    o_result.stack_access = SA_PULL;
                    o_result.stack_slot   = s + 8'd1;
                    if (hi == IMP_PLP) begin
                        o_state.p = (v & PLP_KEEP_MASK) | PLP_SET_MASK;
                    end else begin
                        o_state.a = v;
                        o_state.p = f_nz(p, v);
                    end
                end
                IMP_DEY: begin
                    o_state.y = y - 8'd1;
                    o_state.p = f_nz(p, y - 8'd1);
                end
                IMP_TAY: begin
                    o_state.y = a;
                    o_state.p = f_nz(p, a);
                end
                IMP_INY: begin
                    o_state.y = y + 8'd1;
                    o_state.p = f_nz(p, y + 8'd1);
                end
                default: begin
                    o_state.x = x + 8'd1;
                    o_state.p = f_nz(p, x + 8'd1);
                end
            endcase
        end else if (lo == LO_CTL) begin
            if (hi == HI_BIT && (mid == MID_ZP || mid == MID_ABS)) begin
                o_state.p = {v[7:6], p[5:2], (a & v) == 8'h00, p[0]};
            end else if (hi == HI_STOR && (mid == MID_ZP || mid == MID_ABS ||
                                           mid == MID_ZPX)) begin
                o_result.result_byte = y;
                o_result.write_back  = 1'b1;
            end else if (hi == HI_LOAD && (mid == MID_IMM || odd)) begin
                o_state.y = v;
                o_state.p = f_nz(p, v);
            end else if (hi[2] && hi[1] && (mid == MID_IMM || mid == MID_ZP ||
                                            mid == MID_ABS)) begin
                o_state.p = f_cmp(p, (hi == HI_CPY) ? y : x, v);
            end
        end else if (lo == LO_RMW) begin
            if (i_opcode == OP_TXA) begin
                o_state.a = x;
                o_state.p = f_nz(p, x);
            end else if (i_opcode == OP_TAX) begin
                o_state.x = a;
                o_state.p = f_nz(p, a);
            end else if (i_opcode == OP_DEX) begin
                o_state.x = x - 8'd1;
                o_state.p = f_nz(p, x - 8'd1);
            end else if (i_opcode == OP_TXS) begin
                o_state.s = x;
            end else if (i_opcode == OP_TSX) begin
                o_state.x = s;
                o_state.p = f_nz(p, s);
            end else if (hi == HI_STOR && (mid == MID_ZP || mid == MID_ABS ||
                                           mid == MID_ZPX)) begin
                o_result.result_byte = x;
                o_result.write_back  = 1'b1;
            end else if (hi == HI_LOAD && (mid == MID_IMM || odd)) begin
                o_state.x = v;
                o_state.p = f_nz(p, v);
            end else if (hi[2] && hi[1] && odd) begin
                o_result.result_byte = rmw_val;
                o_result.write_back  = 1'b1;
                o_state.p            = f_nz(p, rmw_val);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cpu6502_execute_unit.sv]
// Top level: 6502 execute unit with input register, execute logic and result register.
//
//   channel  dir  payload                                       transfer when
//   i_in     in   opcode, operand                               valid & ready
//   o_out    out  result_byte .. stack_pointer_out              valid & ready
//
// Items pass input then result register; one item per cycle unless the output stalls.
// Execute logic sits between the input register and the result register; the
// architectural registers update on the edge that loads the result register.
// A stalled result holds the register file, so the *_out fields come straight from it.
// Reset sets A, X, Y to 0, status to 0x20, SP to 0xFF and empties both stages.
`default_nettype none

module cpu6502_execute_unit
    import cpu65_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    cpu65_in_if.sink           i_in,
    cpu65_out_if.source        o_out
);

    logic         r_in_vld;
    logic [7:0]   r_opcode;
    logic [7:0]   r_operand;
    logic         r_out_vld;
    t_exec_result r_result;
    t_cpu_state   r_state;

    t_cpu_state   n_state;
    t_exec_result n_result;
    logic         out_load;
    logic         in_take;

    assign out_load   = r_in_vld && (!r_out_vld || o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || out_load;

    cpu65_exec u_exec (
        .i_state   (r_state),
        .i_opcode  (r_opcode),
        .i_operand (r_operand),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{a: RST_ACC, x: RST_INDEX, y: RST_INDEX, p: RST_STATUS, s: RST_SP};
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode  <= i_in.opcode;
            r_operand <= i_in.operand;
        end
        if (out_load) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.result_byte       = r_result.result_byte;
    assign o_out.write_back        = r_result.write_back;
    assign o_out.branch_taken      = r_result.branch_taken;
    assign o_out.stack_access      = r_result.stack_access;
    assign o_out.stack_slot        = r_result.stack_slot;
    assign o_out.acc_out           = r_state.a;
    assign o_out.index_x_out       = r_state.x;
    assign o_out.index_y_out       = r_state.y;
    assign o_out.status_out        = r_state.p;
    assign o_out.stack_pointer_out = r_state.s;

endmodule

`default_nettype wire

[test/cpu6502_execute_checker.sv]
// Checker: watches both channels, predicts each execute result and compares it field by field.
module cpu6502_execute_checker
    import cpu65_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpu65_in_if   i_in,
    cpu65_out_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]   opcode;
        t_exec_result res;
        t_cpu_state   st;
    } exec_expect_t;

    t_cpu_state   cpu_regs;
    exec_expect_t result_q[$];
    int           fail_total = 0;

    function automatic logic [7:0] nz_flags(input logic [7:0] p, input logic [7:0] v);
        return {v[7], p[6:2], v == 8'h00, p[0]};
    endfunction

    function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] reg_val,
                                             input logic [7:0] val);
        logic [7:0] diff;
        diff = reg_val - val;
        return {diff[7], p[6:2], reg_val == val, reg_val >= val};
    endfunction

    function automatic void exec_predict(input logic [7:0] op, input logic [7:0] val,
                                         inout t_cpu_state st, output t_exec_result r);
        logic [2:0] hi;
        logic [2:0] mid;
        logic [1:0] lo;
        logic [7:0] addend;
        logic [8:0] sum;
        logic [7:0] src;
        logic [7:0] sh;
        logic       cout;
        logic       cond;
        hi  = op[7:5];
        mid = op[4:2];
        lo  = op[1:0];
        r   = '0;
        if (lo == LO_ALU) begin
            case (hi)
                ALU_ORA: st.a = st.a | val;
                ALU_AND: st.a = st.a & val;
                ALU_EOR: st.a = st.a ^ val;
                ALU_LDA: st.a = val;
                ALU_STA: begin
                    if (mid != MID_IMPL) begin
                        r.result_byte = st.a;
                        r.write_back  = 1'b1;
                    end
                end
                ALU_CMP: st.p = cmp_flags(st.p, st.a, val);
                ALU_ADC, ALU_SBC: begin
                    addend = (hi == ALU_SBC) ? ~val : val;
                    sum = {1'b0, st.a} + {1'b0, addend} + {8'd0, st.p[FLAG_C_BIT]};
                    st.p[FLAG_C_BIT] = sum[8];
                    st.p[FLAG_V_BIT] = (st.a[7] == addend[7]) && (sum[7] != st.a[7]);
                    st.a = sum[7:0];
                end
                default: ;
            endcase
            if (hi != ALU_STA && hi != ALU_CMP) st.p = nz_flags(st.p, st.a);
        end else if (lo == LO_RMW && !hi[2]) begin
            // hi[1]: shift right, hi[0]: rotate through carry
            if (mid == MID_IMPL || mid[0]) begin
                src = (mid == MID_IMPL) ? st.a : val;
                if (hi[1]) begin
                    cout = src[0];
                    sh   = {hi[0] & st.p[FLAG_C_BIT], src[7:1]};
                end else begin
                    cout = src[7];
                    sh   = {src[6:0], hi[0] & st.p[FLAG_C_BIT]};
                end
                st.p[FLAG_C_BIT] = cout;
                st.p = nz_flags(st.p, sh);
                if (mid == MID_IMPL) begin
                    st.a = sh;
                end else begin
                    r.result_byte = sh;
                    r.write_back  = 1'b1;
                end
            end
        end else if (lo == LO_CTL && mid == MID_BR) begin
            case (hi[2:1])
                2'd0:    cond = st.p[FLAG_N_BIT];
                2'd1:    cond = st.p[FLAG_V_BIT];
                2'd2:    cond = st.p[FLAG_C_BIT];
                default: cond = st.p[FLAG_Z_BIT];
            endcase
            r.branch_taken = (cond == hi[0]);
        end else if (lo == LO_CTL && mid == MID_FLG) begin
            if (hi == HI_TYA) begin
                st.a = st.y;
                st.p = nz_flags(st.p, st.a);
            end else if (hi == HI_CLV) begin
                st.p[FLAG_V_BIT] = 1'b0;
            end else begin
                case (hi[2:1])
                    2'd0:    st.p[FLAG_C_BIT] = hi[0];
                    2'd1:    st.p[FLAG_I_BIT] = hi[0];
                    default: st.p[FLAG_D_BIT] = hi[0];
                endcase
            end
        end else if (lo == LO_CTL && mid == MID_IMPL) begin
            case (hi)
                IMP_PHP, IMP_PHA: begin
                    r.result_byte  = (hi == IMP_PHP) ? (st.p | PHP_SET_MASK) : st.a;
                    r.write_back   = 1'b1;
                    r.stack_access = SA_PUSH;
                    r.stack_slot   = st.s;
                    st.s = st.s - 8'd1;
                end
                IMP_PLP, IMP_PLA: begin
                    st.s = st.s + 8'd1;
                    r.stack_access = SA_PULL;
                    r.stack_slot   = st.s;
                    if (hi == IMP_PLP) begin
                        st.p = (val & PLP_KEEP_MASK) | PLP_SET_MASK;
                    end else begin
                        st.a = val;
                        st.p = nz_flags(st.p, val);
                    end
                end
                IMP_DEY: begin
                    st.y = st.y - 8'd1;
                    st.p = nz_flags(st.p, st.y);
                end
                IMP_TAY: begin
                    st.y = st.a;
                    st.p = nz_flags(st.p, st.y);
                end
                IMP_INY: begin
                    st.y = st.y + 8'd1;
                    st.p = nz_flags(st.p, st.y);
                end
                default: begin
                    st.x = st.x + 8'd1;
                    st.p = nz_flags(st.p, st.x);
                end
            endcase
        end else if (lo == LO_CTL) begin
            if (hi == HI_BIT && (mid == MID_ZP || mid == MID_ABS)) begin
                st.p[FLAG_N_BIT] = val[7];
                st.p[FLAG_V_BIT] = val[6];
                st.p[FLAG_Z_BIT] = ((st.a & val) == 8'h00);
            end else if (hi == HI_STOR && (mid == MID_ZP || mid == MID_ABS || mid == MID_ZPX)) begin
                r.result_byte = st.y;
                r.write_back  = 1'b1;
            end else if (hi == HI_LOAD && (mid == MID_IMM || mid[0])) begin
                st.y = val;
                st.p = nz_flags(st.p, val);
            end else if (hi[2:1] == 2'b11 && (mid == MID_IMM || mid == MID_ZP || mid == MID_ABS)) begin
                st.p = cmp_flags(st.p, (hi == HI_CPY) ? st.y : st.x, val);
            end
        end else if (lo == LO_RMW) begin
            if (op == OP_TXA) begin
                st.a = st.x;
                st.p = nz_flags(st.p, st.a);
            end else if (op == OP_TAX) begin
                st.x = st.a;
                st.p = nz_flags(st.p, st.x);
            end else if (op == OP_DEX) begin
                st.x = st.x - 8'd1;
                st.p = nz_flags(st.p, st.x);
            end else if (op == OP_TXS) begin
                st.s = st.x;
            end else if (op == OP_TSX) begin
                st.x = st.s;
                st.p = nz_flags(st.p, st.x);
            end else if (hi == HI_STOR && (mid == MID_ZP || mid == MID_ABS || mid == MID_ZPX)) begin
                r.result_byte = st.x;
                r.write_back  = 1'b1;
            end else if (hi == HI_LOAD && (mid == MID_IMM || mid[0])) begin
                st.x = val;
                st.p = nz_flags(st.p, val);
            end else if (hi[2:1] == 2'b11 && mid[0]) begin
                // memory DEC / INC
                r.result_byte = hi[0] ? val + 8'd1 : val - 8'd1;
                r.write_back  = 1'b1;
                st.p = nz_flags(st.p, r.result_byte);
            end
        end
    endfunction

    task automatic check_field(input logic [7:0] op, input string name,
                               input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("opcode %02h: %s expected %02h, got %02h", op, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        exec_expect_t want;
        if (!i_rst_n) begin
            cpu_regs = '{a: RST_ACC, x: RST_INDEX, y: RST_INDEX, p: RST_STATUS, s: RST_SP};
            result_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (result_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("result transfer with nothing outstanding");
                end else begin
                    want = result_q.pop_front();
                    check_field(want.opcode, "result_byte", want.res.result_byte,
                                i_out.result_byte);
                    check_field(want.opcode, "write_back", 8'(want.res.write_back),
                                8'(i_out.write_back));
                    check_field(want.opcode, "branch_taken", 8'(want.res.branch_taken),
                                8'(i_out.branch_taken));
                    check_field(want.opcode, "stack_access", 8'(want.res.stack_access),
                                8'(i_out.stack_access));
                    check_field(want.opcode, "stack_slot", want.res.stack_slot,
                                i_out.stack_slot);
                    check_field(want.opcode, "acc_out", want.st.a, i_out.acc_out);
                    check_field(want.opcode, "index_x_out", want.st.x, i_out.index_x_out);
                    check_field(want.opcode, "index_y_out", want.st.y, i_out.index_y_out);
                    check_field(want.opcode, "status_out", want.st.p, i_out.status_out);
                    check_field(want.opcode, "stack_pointer_out", want.st.s,
                                i_out.stack_pointer_out);
                end
            end
            if (i_in.valid && i_in.ready) begin
                want.opcode = i_in.opcode;
                exec_predict(i_in.opcode, i_in.operand, cpu_regs, want.res);
                want.st = cpu_regs;
                result_q.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= result_q.size();
    end

endmodule

[test/tb_cpu6502_execute_unit.sv]
// Testbench top: drives instruction items and result back-pressure, and reports the verdict.
module tb_cpu6502_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cpu65_pkg::*;

    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_ADC_IMM = 8'h69;
    localparam logic [7:0] OP_SBC_IMM = 8'hE9;
    localparam logic [7:0] OP_CMP_IMM = 8'hC9;
    localparam logic [7:0] OP_AND_IMM = 8'h29;
    localparam logic [7:0] OP_EOR_IMM = 8'h49;
    localparam logic [7:0] OP_SED     = 8'hF8;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_ROR_A   = 8'h6A;
    localparam logic [7:0] OP_ASL_A   = 8'h0A;
    localparam logic [7:0] OP_ASL_ZP  = 8'h06;
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_PLP     = 8'h28;
    localparam logic [7:0] OP_PHP     = 8'h08;
    localparam logic [7:0] OP_BEQ     = 8'hF0;
    localparam logic [7:0] OP_BMI     = 8'h30;
    localparam logic [7:0] OP_STA_IMM = 8'h89;
    localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
    localparam logic [7:0] OP_INC_ZP  = 8'hE6;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_ILLEGAL = 8'h02;

    localparam int ITEMS_PER_PHASE = 330;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SEND_IDLE [4]   = '{0, 71, 0, 15};
    localparam int RECV_STALL [4]  = '{0, 0, 71, 15};

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_req = 0;
    int   fail_count;
    int   pending;

    cpu65_in_if  in_ch ();
    cpu65_out_if out_ch ();

    cpu6502_execute_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cpu6502_execute_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [7:0] op, input logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.operand <= val;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random();
        logic [7:0] op;
        logic [7:0] val;
        op = 8'($urandom);
        if ($urandom_range(99) < 85)
            while (op[1:0] == 2'b11) op = 8'($urandom);
        case ($urandom_range(9))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            2:       val = 8'h80;
            3:       val = 8'h7F;
            default: val = 8'($urandom);
        endcase
        send_item(op, val);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.opcode  <= 8'h00;
        in_ch.operand <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // overflow and carry on add/subtract, compare, logic ops, binary add with D set, shifts, BIT
        send_item(OP_LDA_IMM, 8'h80);
        send_item(OP_ADC_IMM, 8'h80);
        send_item(OP_ADC_IMM, 8'h7F);
        send_item(OP_SBC_IMM, 8'hFF);
        send_item(OP_CMP_IMM, 8'h80);
        send_item(OP_AND_IMM, 8'h00);
        send_item(OP_EOR_IMM, 8'hFF);
        send_item(OP_SED, 8'h00);
        send_item(OP_ADC_IMM, 8'h09);
        send_item(OP_SEC, 8'h00);
        send_item(OP_ROR_A, 8'h00);
        send_item(OP_ASL_A, 8'h00);
        send_item(OP_ASL_ZP, 8'h81);
        send_item(OP_BIT_ZP, 8'hC0);
        // stack pointer wraps on push and on pull
        send_item(OP_LDX_IMM, 8'h00);
        send_item(OP_TXS, 8'h00);
        send_item(OP_PHA, 8'h00);
        send_item(OP_PLA, 8'h00);
        send_item(OP_PLP, 8'hFF);
        send_item(OP_PHP, 8'h00);
        send_item(OP_BEQ, 8'h00);
        send_item(OP_BMI, 8'h00);
        send_item(OP_STA_IMM, 8'h55);
        send_item(OP_DEC_ZP, 8'h00);
        send_item(OP_INC_ZP, 8'hFF);
        send_item(OP_DEX, 8'h00);
        send_item(OP_CPX_IMM, 8'hFF);
        send_item(OP_ILLEGAL, 8'hA5);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            repeat (ITEMS_PER_PHASE) send_random();
            if (ph == 0) begin
                // fill the pipe against a blocked output, then let it empty
                hold_req = HOLD_CYCLES;
                repeat (PRESSURE_ITEMS) send_random();
                drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
